// ----- rtl/ivpb_pkg.sv -----
// Package for the INS velocity and position blender.
// Holds item types, register indexes, sequencer states and saturation helpers.
// No dependencies.
`default_nettype none
package ivpb_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
  localparam logic [2:0] REG_VEL_BLEND   = 3'd1;
  localparam logic [2:0] REG_POS_BLEND   = 3'd2;
  localparam logic [2:0] REG_SIN_LAT     = 3'd3;
  localparam logic [2:0] REG_COS_LAT     = 3'd4;
  localparam logic [2:0] REG_SIN_LON     = 3'd5;
  localparam logic [2:0] REG_COS_LON     = 3'd6;

  localparam int CFG_W   = 24;
  localparam int ACC_W   = 66;
  localparam int SUM_W   = 52;

  localparam logic [23:0] RST_STEP_PERIOD = 24'd167772;
  localparam logic [15:0] ONE_Q15         = 16'h8000;
  localparam logic [15:0] RST_COS         = 16'h7fff;

  // One input item.
  typedef struct packed {
    logic signed [31:0] acc_north;
    logic signed [31:0] acc_east;
    logic signed [31:0] acc_down;
    logic signed [31:0] vel_meas_north;
    logic signed [31:0] vel_meas_east;
    logic signed [31:0] vel_meas_down;
    logic signed [47:0] pos_meas_x;
    logic signed [47:0] pos_meas_y;
    logic signed [47:0] pos_meas_z;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] est_vel_north;
    logic signed [31:0] est_vel_east;
    logic signed [31:0] est_vel_down;
    logic signed [47:0] est_pos_x;
    logic signed [47:0] est_pos_y;
    logic signed [47:0] est_pos_z;
  } out_item_t;

  // Sequencer steps. A multiply step holds its state until its registered product is accumulated.
  typedef enum logic [5:0] {
    S_IDLE,
    S_VTRAP, S_VWB_T, S_VB_EST, S_VB_MEAS, S_VWB_B,
    S_TRIG0, S_TRIG1, S_TRIG2, S_TRIG3,
    S_X0, S_X1, S_X2, S_XWB,
    S_Y0, S_Y1, S_Y2, S_YWB,
    S_Z0, S_Z1, S_ZWB,
    S_PTRAP, S_PWB_T, S_PB0, S_PB1, S_PB2, S_PB3, S_PWB_B,
    S_OUT
  } ivpb_state_t;

  // Saturate a wide sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7fffffff);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Saturate a wide sum to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7fffffffffff);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return 48'sh7fffffffffff;
    end else if (v < lo) begin
      return 48'sh800000000000;
    end
    return v[47:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ivpb_in_if.sv -----
// Input channel of the blender: valid, ready and one input item.
// Depends on ivpb_pkg.
`default_nettype none
interface ivpb_in_if;
  logic               valid;
  logic               ready;
  ivpb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ivpb_out_if.sv -----
// Output channel of the blender: valid, ready and one result item.
// Depends on ivpb_pkg.
`default_nettype none
interface ivpb_out_if;
  logic                valid;
  logic                ready;
  ivpb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ins_velocity_position_blender.sv -----
// INS velocity and position blender, top level.
// Depends on ivpb_pkg, ivpb_in_if and ivpb_out_if.
//
// Each item integrates a NED acceleration into the velocity estimate, blends
// it with a full velocity fix, rotates it to ECEF, integrates it into the
// position estimate and blends that with a full position fix. All products
// go through one shared 33 x 33 signed multiplier whose result is registered.
// The blend steps run only for a fix that is present, and a result waits on
// the output until it is taken. A new item is taken at the earliest in the
// cycle after the result has been handed over.
`default_nettype none
module ins_velocity_position_blender (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [2:0]                  wr_index,
  input  wire logic [ivpb_pkg::CFG_W-1:0]  wr_data,
  ivpb_in_if.sink                          samples,
  ivpb_out_if.source                       results
);

  // Configuration registers.
  logic        [23:0] step_period;
  logic        [15:0] vel_blend;
  logic        [15:0] pos_blend;
  logic signed [15:0] sin_lat;
  logic signed [15:0] cos_lat;
  logic signed [15:0] sin_lon;
  logic signed [15:0] cos_lon;

  // Filter state.
  logic signed [31:0] vel [3];
  logic signed [47:0] pos [3];
  logic signed [31:0] last_acc [3];
  logic signed [31:0] last_ecef [3];
  logic signed [31:0] ecef [3];

  // Trig products for the rotation.
  logic signed [31:0] clcl;
  logic signed [31:0] clsl;
  logic signed [31:0] slcl;
  logic signed [31:0] slsl;

  ivpb_pkg::ivpb_state_t state;
  ivpb_pkg::ivpb_state_t state_next;
  logic                  phase;
  logic [1:0]            ax;
  ivpb_pkg::in_item_t    item;

  logic signed [ivpb_pkg::ACC_W-1:0] prod;
  logic signed [ivpb_pkg::ACC_W-1:0] acc;

  // Multiplier control from the sequencer.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic               is_mul;
  logic               acc_clr;
  logic               acc_sub;
  logic               acc_sh24;

  logic signed [31:0] in_acc [3];
  logic signed [31:0] in_vm [3];
  logic signed [47:0] in_pm [3];
  logic               vel_fix;
  logic               pos_fix;
  logic        [16:0] cv;
  logic        [16:0] cp;
  logic               last_ax;

  logic signed [ivpb_pkg::ACC_W-1:0] r15;
  logic signed [ivpb_pkg::ACC_W-1:0] r25;
  logic signed [ivpb_pkg::ACC_W-1:0] r30;
  logic signed [ivpb_pkg::ACC_W-1:0] term;
  logic signed [ivpb_pkg::SUM_W-1:0] vel_sum;
  logic signed [ivpb_pkg::SUM_W-1:0] pos_sum;

  // Unpack the held item and derive fix flags and clamped weights.
  always_comb begin
    in_acc[0] = item.acc_north;
    in_acc[1] = item.acc_east;
    in_acc[2] = item.acc_down;
    in_vm[0]  = item.vel_meas_north;
    in_vm[1]  = item.vel_meas_east;
    in_vm[2]  = item.vel_meas_down;
    in_pm[0]  = item.pos_meas_x;
    in_pm[1]  = item.pos_meas_y;
    in_pm[2]  = item.pos_meas_z;
    vel_fix = (in_vm[0] != '0) && (in_vm[1] != '0) && (in_vm[2] != '0);
    pos_fix = (in_pm[0] != '0) && (in_pm[1] != '0) && (in_pm[2] != '0);
    cv = (vel_blend > ivpb_pkg::ONE_Q15) ? {1'b0, ivpb_pkg::ONE_Q15} : {1'b0, vel_blend};
    cp = (pos_blend > ivpb_pkg::ONE_Q15) ? {1'b0, ivpb_pkg::ONE_Q15} : {1'b0, pos_blend};
    last_ax = (ax == 2'd2);
  end

  // Rounded views of the accumulator and the integrator sums.
  always_comb begin
    r15 = (acc + (ivpb_pkg::ACC_W'(1) <<< 14)) >>> 15;
    r25 = (acc + (ivpb_pkg::ACC_W'(1) <<< 24)) >>> 25;
    r30 = (acc + (ivpb_pkg::ACC_W'(1) <<< 29)) >>> 30;
    vel_sum = {{20{vel[ax][31]}}, vel[ax]} + r25[ivpb_pkg::SUM_W-1:0];
    pos_sum = {{4{pos[ax][47]}}, pos[ax]} + r25[ivpb_pkg::SUM_W-1:0];
    term = acc_sh24 ? (prod <<< 24) : prod;
  end

  // Next step of the sequencer.
  always_comb begin
    state_next = state;
    if (is_mul && !phase) begin
      state_next = state;
    end else begin
      unique case (state)
        ivpb_pkg::S_IDLE:    if (samples.valid) state_next = ivpb_pkg::S_VTRAP;
        ivpb_pkg::S_VTRAP:   state_next = ivpb_pkg::S_VWB_T;
        ivpb_pkg::S_VWB_T: begin
          if (vel_fix) state_next = ivpb_pkg::S_VB_EST;
          else state_next = last_ax ? ivpb_pkg::S_TRIG0 : ivpb_pkg::S_VTRAP;
        end
        ivpb_pkg::S_VB_EST:  state_next = ivpb_pkg::S_VB_MEAS;
        ivpb_pkg::S_VB_MEAS: state_next = ivpb_pkg::S_VWB_B;
        ivpb_pkg::S_VWB_B:   state_next = last_ax ? ivpb_pkg::S_TRIG0 : ivpb_pkg::S_VTRAP;
        ivpb_pkg::S_TRIG0:   state_next = ivpb_pkg::S_TRIG1;
        ivpb_pkg::S_TRIG1:   state_next = ivpb_pkg::S_TRIG2;
        ivpb_pkg::S_TRIG2:   state_next = ivpb_pkg::S_TRIG3;
        ivpb_pkg::S_TRIG3:   state_next = ivpb_pkg::S_X0;
        ivpb_pkg::S_X0:      state_next = ivpb_pkg::S_X1;
        ivpb_pkg::S_X1:      state_next = ivpb_pkg::S_X2;
        ivpb_pkg::S_X2:      state_next = ivpb_pkg::S_XWB;
        ivpb_pkg::S_XWB:     state_next = ivpb_pkg::S_Y0;
        ivpb_pkg::S_Y0:      state_next = ivpb_pkg::S_Y1;
        ivpb_pkg::S_Y1:      state_next = ivpb_pkg::S_Y2;
        ivpb_pkg::S_Y2:      state_next = ivpb_pkg::S_YWB;
        ivpb_pkg::S_YWB:     state_next = ivpb_pkg::S_Z0;
        ivpb_pkg::S_Z0:      state_next = ivpb_pkg::S_Z1;
        ivpb_pkg::S_Z1:      state_next = ivpb_pkg::S_ZWB;
        ivpb_pkg::S_ZWB:     state_next = ivpb_pkg::S_PTRAP;
        ivpb_pkg::S_PTRAP:   state_next = ivpb_pkg::S_PWB_T;
        ivpb_pkg::S_PWB_T: begin
          if (pos_fix) state_next = ivpb_pkg::S_PB0;
          else state_next = last_ax ? ivpb_pkg::S_OUT : ivpb_pkg::S_PTRAP;
        end
        ivpb_pkg::S_PB0:     state_next = ivpb_pkg::S_PB1;
        ivpb_pkg::S_PB1:     state_next = ivpb_pkg::S_PB2;
        ivpb_pkg::S_PB2:     state_next = ivpb_pkg::S_PB3;
        ivpb_pkg::S_PB3:     state_next = ivpb_pkg::S_PWB_B;
        ivpb_pkg::S_PWB_B:   state_next = last_ax ? ivpb_pkg::S_OUT : ivpb_pkg::S_PTRAP;
        ivpb_pkg::S_OUT:     if (results.ready) state_next = ivpb_pkg::S_IDLE;
        default:             state_next = ivpb_pkg::S_IDLE;
      endcase
    end
  end

  // Multiplier operands and accumulate mode for each step.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    is_mul   = 1'b1;
    acc_clr  = 1'b0;
    acc_sub  = 1'b0;
    acc_sh24 = 1'b0;
    unique case (state)
      ivpb_pkg::S_VTRAP: begin
        mul_a   = {last_acc[ax][31], last_acc[ax]} + {in_acc[ax][31], in_acc[ax]};
        mul_b   = {9'b0, step_period};
        acc_clr = 1'b1;
      end
      ivpb_pkg::S_VB_EST: begin
        mul_a   = {vel[ax][31], vel[ax]};
        mul_b   = {16'b0, cv};
        acc_clr = 1'b1;
      end
      ivpb_pkg::S_VB_MEAS: begin
        mul_a = {in_vm[ax][31], in_vm[ax]};
        mul_b = {16'b0, {1'b0, ivpb_pkg::ONE_Q15} - cv};
      end
      ivpb_pkg::S_TRIG0: begin
        mul_a = 33'(cos_lon);
        mul_b = 33'(cos_lat);
      end
      ivpb_pkg::S_TRIG1: begin
        mul_a = 33'(cos_lon);
        mul_b = 33'(sin_lat);
      end
      ivpb_pkg::S_TRIG2: begin
        mul_a = 33'(sin_lon);
        mul_b = 33'(cos_lat);
      end
      ivpb_pkg::S_TRIG3: begin
        mul_a = 33'(sin_lon);
        mul_b = 33'(sin_lat);
      end
      ivpb_pkg::S_X0: begin
        mul_a   = 33'(vel[2]);
        mul_b   = 33'(clcl);
        acc_clr = 1'b1;
        acc_sub = 1'b1;
      end
      ivpb_pkg::S_X1: begin
        mul_a   = 33'(vel[0]);
        mul_b   = 33'(clsl);
        acc_sub = 1'b1;
      end
      ivpb_pkg::S_X2: begin
        mul_a   = 33'(vel[1]);
        mul_b   = {{2{sin_lon[15]}}, sin_lon, 15'b0};
        acc_sub = 1'b1;
      end
      ivpb_pkg::S_Y0: begin
        mul_a   = 33'(vel[2]);
        mul_b   = 33'(slcl);
        acc_clr = 1'b1;
        acc_sub = 1'b1;
      end
      ivpb_pkg::S_Y1: begin
        mul_a   = 33'(vel[0]);
        mul_b   = 33'(slsl);
        acc_sub = 1'b1;
      end
      ivpb_pkg::S_Y2: begin
        mul_a = 33'(vel[1]);
        mul_b = {{2{cos_lon[15]}}, cos_lon, 15'b0};
      end
      ivpb_pkg::S_Z0: begin
        mul_a   = 33'(vel[0]);
        mul_b   = 33'(cos_lat);
        acc_clr = 1'b1;
      end
      ivpb_pkg::S_Z1: begin
        mul_a   = 33'(vel[2]);
        mul_b   = 33'(sin_lat);
        acc_sub = 1'b1;
      end
      ivpb_pkg::S_PTRAP: begin
        mul_a   = {last_ecef[ax][31], last_ecef[ax]} + {ecef[ax][31], ecef[ax]};
        mul_b   = {9'b0, step_period};
        acc_clr = 1'b1;
      end
      // Position blend splits each 48-bit operand into a low and a high half.
      ivpb_pkg::S_PB0: begin
        mul_a   = {9'b0, pos[ax][23:0]};
        mul_b   = {16'b0, cp};
        acc_clr = 1'b1;
      end
      ivpb_pkg::S_PB1: begin
        mul_a    = {{9{pos[ax][47]}}, pos[ax][47:24]};
        mul_b    = {16'b0, cp};
        acc_sh24 = 1'b1;
      end
      ivpb_pkg::S_PB2: begin
        mul_a = {9'b0, in_pm[ax][23:0]};
        mul_b = {16'b0, {1'b0, ivpb_pkg::ONE_Q15} - cp};
      end
      ivpb_pkg::S_PB3: begin
        mul_a    = {{9{in_pm[ax][47]}}, in_pm[ax][47:24]};
        mul_b    = {16'b0, {1'b0, ivpb_pkg::ONE_Q15} - cp};
        acc_sh24 = 1'b1;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  // Handshake outputs and the result item.
  always_comb begin
    samples.ready              = (state == ivpb_pkg::S_IDLE);
    results.valid              = (state == ivpb_pkg::S_OUT);
    results.data.est_vel_north = vel[0];
    results.data.est_vel_east  = vel[1];
    results.data.est_vel_down  = vel[2];
    results.data.est_pos_x     = pos[0];
    results.data.est_pos_y     = pos[1];
    results.data.est_pos_z     = pos[2];
  end

  // Sequencer, configuration and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ivpb_pkg::S_IDLE;
      phase       <= 1'b0;
      ax          <= '0;
      step_period <= ivpb_pkg::RST_STEP_PERIOD;
      vel_blend   <= ivpb_pkg::ONE_Q15;
      pos_blend   <= ivpb_pkg::ONE_Q15;
      sin_lat     <= '0;
      cos_lat     <= ivpb_pkg::RST_COS;
      sin_lon     <= '0;
      cos_lon     <= ivpb_pkg::RST_COS;
      for (int i = 0; i < 3; i++) begin
        vel[i]       <= '0;
        pos[i]       <= '0;
        last_acc[i]  <= '0;
        last_ecef[i] <= '0;
      end
    end else begin
      state <= state_next;
      phase <= is_mul && !phase;

      // Configuration writes; unknown indexes are ignored.
      if (wr_en) begin
        unique case (wr_index)
          ivpb_pkg::REG_STEP_PERIOD: step_period <= wr_data[23:0];
          ivpb_pkg::REG_VEL_BLEND:   vel_blend   <= wr_data[15:0];
          ivpb_pkg::REG_POS_BLEND:   pos_blend   <= wr_data[15:0];
          ivpb_pkg::REG_SIN_LAT:     sin_lat     <= wr_data[15:0];
          ivpb_pkg::REG_COS_LAT:     cos_lat     <= wr_data[15:0];
          ivpb_pkg::REG_SIN_LON:     sin_lon     <= wr_data[15:0];
          ivpb_pkg::REG_COS_LON:     cos_lon     <= wr_data[15:0];
          default: ;
        endcase
      end

      // Write-back steps.
      unique case (state)
        ivpb_pkg::S_IDLE: begin
          ax <= '0;
        end
        ivpb_pkg::S_VWB_T: begin
          vel[ax]      <= ivpb_pkg::sat32(vel_sum);
          last_acc[ax] <= in_acc[ax];
          if (!vel_fix) ax <= last_ax ? 2'd0 : ax + 2'd1;
        end
        ivpb_pkg::S_VWB_B: begin
          vel[ax] <= ivpb_pkg::sat32(r15[ivpb_pkg::SUM_W-1:0]);
          ax      <= last_ax ? 2'd0 : ax + 2'd1;
        end
        ivpb_pkg::S_XWB: ecef[0] <= ivpb_pkg::sat32(r30[ivpb_pkg::SUM_W-1:0]);
        ivpb_pkg::S_YWB: ecef[1] <= ivpb_pkg::sat32(r30[ivpb_pkg::SUM_W-1:0]);
        ivpb_pkg::S_ZWB: ecef[2] <= ivpb_pkg::sat32(r15[ivpb_pkg::SUM_W-1:0]);
        ivpb_pkg::S_PWB_T: begin
          pos[ax]       <= ivpb_pkg::sat48(pos_sum);
          last_ecef[ax] <= ecef[ax];
          if (!pos_fix) ax <= last_ax ? 2'd0 : ax + 2'd1;
        end
        ivpb_pkg::S_PWB_B: begin
          pos[ax] <= ivpb_pkg::sat48(r15[ivpb_pkg::SUM_W-1:0]);
          ax      <= last_ax ? 2'd0 : ax + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Shared multiplier, accumulator, trig products and the held item.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (samples.valid && samples.ready) begin
      item <= samples.data;
    end
    if (is_mul && phase) begin
      acc <= (acc_clr ? '0 : acc) + (acc_sub ? -term : term);
      unique case (state)
        ivpb_pkg::S_TRIG0: clcl <= prod[31:0];
        ivpb_pkg::S_TRIG1: clsl <= prod[31:0];
        ivpb_pkg::S_TRIG2: slcl <= prod[31:0];
        ivpb_pkg::S_TRIG3: slsl <= prod[31:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- test/ivpb_checker.sv -----
// Checker for the INS velocity and position blender: predicts each result item
// from accepted input items and compares it field by field.
// Depends on ivpb_pkg, ivpb_in_if and ivpb_out_if.
`timescale 1ns / 100ps
module ivpb_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [2:0]                 wr_index,
  input  wire logic [ivpb_pkg::CFG_W-1:0] wr_data,
  ivpb_in_if.sink                         samples_mon,
  ivpb_out_if.sink                        results_mon,
  output int                              fail_count,
  output int                              pending_count
);

  // Shadow registers and filter state.
  logic [23:0]         dt_q;
  logic [15:0]         vel_c_q, pos_c_q;
  logic signed [15:0]  slat_q, clat_q, slon_q, clon_q;
  logic signed [63:0]  vel_st[3], pos_st[3], acc_prev[3], ecef_prev[3];
  ivpb_pkg::out_item_t expected_q[$];

  // Round half up, then arithmetic shift right.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    logic signed [63:0] u;
    u = v + (64'sd1 <<< (s - 1));
    return u >>> s;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic logic signed [63:0] trap_inc(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    return rnd_shr((a + b) * $signed({40'd0, dt_q}), 25);
  endfunction

  function automatic logic signed [63:0] mix(input logic signed [63:0] est,
                                             input logic signed [63:0] meas,
                                             input logic [15:0] c_raw, input int w);
    logic signed [63:0] c;
    c = (c_raw > 16'h8000) ? 64'sd32768 : $signed({48'd0, c_raw});
    return clamp(rnd_shr(est * c + meas * (64'sd32768 - c), 15), w);
  endfunction

  // Advance the filter by one input item and queue the expected result.
  task automatic predict_step(input ivpb_pkg::in_item_t it);
    logic signed [63:0] acc[3], vm[3], pm[3], ecef[3];
    logic signed [63:0] t, n, e, d;
    logic vfix, pfix;
    ivpb_pkg::out_item_t r;
    acc[0] = it.acc_north; acc[1] = it.acc_east; acc[2] = it.acc_down;
    vm[0] = it.vel_meas_north; vm[1] = it.vel_meas_east; vm[2] = it.vel_meas_down;
    pm[0] = it.pos_meas_x; pm[1] = it.pos_meas_y; pm[2] = it.pos_meas_z;
    vfix = vm[0] != 0 && vm[1] != 0 && vm[2] != 0;
    pfix = pm[0] != 0 && pm[1] != 0 && pm[2] != 0;
    for (int i = 0; i < 3; i++) begin
      vel_st[i] = clamp(vel_st[i] + trap_inc(acc_prev[i], acc[i]), 32);
      acc_prev[i] = acc[i];
      if (vfix) vel_st[i] = mix(vel_st[i], vm[i], vel_c_q, 32);
    end
    n = vel_st[0]; e = vel_st[1]; d = vel_st[2];
    t = -(clat_q * d) - slat_q * n;
    ecef[0] = clamp(rnd_shr(clon_q * t - slon_q * e * 64'sd32768, 30), 32);
    ecef[1] = clamp(rnd_shr(slon_q * t + clon_q * e * 64'sd32768, 30), 32);
    ecef[2] = clamp(rnd_shr(clat_q * n - slat_q * d, 15), 32);
    for (int i = 0; i < 3; i++) begin
      pos_st[i] = clamp(pos_st[i] + trap_inc(ecef_prev[i], ecef[i]), 48);
      ecef_prev[i] = ecef[i];
      if (pfix) pos_st[i] = mix(pos_st[i], pm[i], pos_c_q, 48);
    end
    r.est_vel_north = vel_st[0][31:0];
    r.est_vel_east  = vel_st[1][31:0];
    r.est_vel_down  = vel_st[2][31:0];
    r.est_pos_x     = pos_st[0][47:0];
    r.est_pos_y     = pos_st[1][47:0];
    r.est_pos_z     = pos_st[2][47:0];
    expected_q.push_back(r);
  endtask

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    fail_count++;
  endtask

  // Compare one result item with the oldest expectation.
  task automatic compare_result(input ivpb_pkg::out_item_t got);
    ivpb_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result item, expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.est_vel_north !== want.est_vel_north)
      report("est_vel_north", want.est_vel_north, got.est_vel_north);
    if (got.est_vel_east !== want.est_vel_east)
      report("est_vel_east", want.est_vel_east, got.est_vel_east);
    if (got.est_vel_down !== want.est_vel_down)
      report("est_vel_down", want.est_vel_down, got.est_vel_down);
    if (got.est_pos_x !== want.est_pos_x) report("est_pos_x", want.est_pos_x, got.est_pos_x);
    if (got.est_pos_y !== want.est_pos_y) report("est_pos_y", want.est_pos_y, got.est_pos_y);
    if (got.est_pos_z !== want.est_pos_z) report("est_pos_z", want.est_pos_z, got.est_pos_z);
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  // Track writes, inputs and results at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      dt_q <= ivpb_pkg::RST_STEP_PERIOD;
      vel_c_q <= ivpb_pkg::ONE_Q15;
      pos_c_q <= ivpb_pkg::ONE_Q15;
      slat_q <= '0;
      clat_q <= ivpb_pkg::RST_COS;
      slon_q <= '0;
      clon_q <= ivpb_pkg::RST_COS;
      for (int i = 0; i < 3; i++) begin
        vel_st[i] = 0; pos_st[i] = 0; acc_prev[i] = 0; ecef_prev[i] = 0;
      end
      expected_q.delete();
      pending_count = 0;
    end else begin
      if (results_mon.valid && results_mon.ready) compare_result(results_mon.data);
      if (samples_mon.valid && samples_mon.ready) predict_step(samples_mon.data);
      pending_count = expected_q.size();
      if (wr_en) begin
        case (wr_index)
          ivpb_pkg::REG_STEP_PERIOD: dt_q <= wr_data[23:0];
          ivpb_pkg::REG_VEL_BLEND:   vel_c_q <= wr_data[15:0];
          ivpb_pkg::REG_POS_BLEND:   pos_c_q <= wr_data[15:0];
          ivpb_pkg::REG_SIN_LAT:     slat_q <= wr_data[15:0];
          ivpb_pkg::REG_COS_LAT:     clat_q <= wr_data[15:0];
          ivpb_pkg::REG_SIN_LON:     slon_q <= wr_data[15:0];
          ivpb_pkg::REG_COS_LON:     clon_q <= wr_data[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- test/tb_ins_velocity_position_blender.sv -----
// Testbench top for the INS velocity and position blender: drives configuration
// and input items with random idling, and gives the verdict from the checker.
// Depends on ivpb_pkg, both channel interfaces, ivpb_checker and the block.
`timescale 1ns / 100ps
module tb_ins_velocity_position_blender;

  localparam int LIMIT_CYCLES = 1500000;
  // An index that names no register.
  localparam logic [2:0] REG_NONE = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       wr_en = 1'b0;
  logic [2:0]                 wr_index = '0;
  logic [ivpb_pkg::CFG_W-1:0] wr_data = '0;
  int                         fail_count, pending_count;
  int                         cycle_count = 0;
  bit                         calm = 1'b0;
  bit                         hold_sink = 1'b0;

  ivpb_in_if  samples ();
  ivpb_out_if results ();

  ins_velocity_position_blender DUT (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .samples(samples), .results(results)
  );

  ivpb_checker checker_i (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .samples_mon(samples), .results_mon(results),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_ins_velocity_position_blender failed");
      $finish;
    end
  end

  // Result side: random stall bursts, a long hold when asked, none when calm.
  initial begin
    int burst;
    results.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink) begin
        results.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_sink = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 13);
        results.ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end else begin
        results.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // One write; the caller drops the write enable after its last write.
  task automatic write_reg(input logic [2:0] idx, input logic [ivpb_pkg::CFG_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
  endtask

  // Stop offering, wait until nothing is outstanding, then let the block settle.
  task automatic drain();
    samples.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [47:0] pick48(input int kind);
    case (kind)
      0: return 48'h7fffffffffff;
      1: return 48'h800000000000;
      2: return 48'd0;
      3: return 48'({$urandom, $urandom}) & 48'h00000fffffff;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [31:0] pick32(input int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return $urandom & 32'h000fffff;
      default: return $urandom;
    endcase
  endfunction

  // Random input item; realistic magnitudes mostly, fixes usually complete.
  function automatic ivpb_pkg::in_item_t rand_item();
    ivpb_pkg::in_item_t it;
    int vmode, pmode;
    vmode = $urandom_range(0, 9);
    pmode = $urandom_range(0, 9);
    it.acc_north = pick32($urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 4));
    it.acc_east  = pick32($urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 4));
    it.acc_down  = pick32($urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 4));
    it.vel_meas_north = pick32(vmode < 5 ? 4 : $urandom_range(0, 4));
    it.vel_meas_east  = pick32(vmode < 5 ? 4 : $urandom_range(0, 4));
    it.vel_meas_down  = pick32(vmode < 5 ? 4 : $urandom_range(0, 4));
    it.pos_meas_x = pick48(pmode < 5 ? 4 : $urandom_range(0, 4));
    it.pos_meas_y = pick48(pmode < 5 ? 4 : $urandom_range(0, 4));
    it.pos_meas_z = pick48(pmode < 5 ? 4 : $urandom_range(0, 4));
    return it;
  endfunction

  // Offer one item, with random idle bursts before it. Valid stays high on
  // return so that the next item can follow at once; drain drops it.
  task automatic send_item(input ivpb_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    samples.valid <= 1'b1;
    samples.data <= it;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_settings();
    write_reg(ivpb_pkg::REG_STEP_PERIOD,
              $urandom_range(0, 3) == 0 ? 24'hffffff : 24'($urandom_range(1, 400000)));
    write_reg(ivpb_pkg::REG_VEL_BLEND,
              $urandom_range(0, 4) == 0 ? 24'h00ffff : 24'($urandom_range(0, 32768)));
    write_reg(ivpb_pkg::REG_POS_BLEND,
              $urandom_range(0, 4) == 0 ? 24'hab8001 : 24'($urandom_range(0, 32768)));
    write_reg(ivpb_pkg::REG_SIN_LAT, 24'($urandom));
    write_reg(ivpb_pkg::REG_COS_LAT, 24'($urandom));
    write_reg(ivpb_pkg::REG_SIN_LON, 24'($urandom));
    write_reg(ivpb_pkg::REG_COS_LON, 24'($urandom));
    wr_en <= 1'b0;
  endtask

  initial begin
    ivpb_pkg::in_item_t it;
    samples.valid = 1'b0;
    samples.data = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, extremes, partial and full fixes.
    for (int k = 0; k < 20; k++) begin
      it.acc_north = pick32(k % 5);
      it.acc_east  = pick32((k + 1) % 5);
      it.acc_down  = pick32((k + 3) % 5);
      it.vel_meas_north = pick32(k < 10 ? 4 : (k % 3 == 0 ? 2 : 0));
      it.vel_meas_east  = pick32(k < 10 ? 1 : 4);
      it.vel_meas_down  = pick32(k % 4 == 1 ? 2 : 4);
      it.pos_meas_x = pick48(k % 6 == 2 ? 2 : 4);
      it.pos_meas_y = pick48(k < 10 ? 0 : 1);
      it.pos_meas_z = pick48(4);
      send_item(it);
      if (k == 9) begin
        drain();
        // Zero period, weights over one and zero, trig extremes, unknown index.
        write_reg(ivpb_pkg::REG_STEP_PERIOD, 24'd0);
        write_reg(ivpb_pkg::REG_VEL_BLEND, 24'hffffff);
        write_reg(ivpb_pkg::REG_POS_BLEND, 24'd0);
        write_reg(ivpb_pkg::REG_SIN_LAT, 24'hff8000);
        write_reg(ivpb_pkg::REG_COS_LAT, 24'h007fff);
        write_reg(ivpb_pkg::REG_SIN_LON, 24'h008000);
        write_reg(ivpb_pkg::REG_COS_LON, 24'h127fff);
        write_reg(REG_NONE, 24'h123456);
        wr_en <= 1'b0;
      end
    end
    drain();

    // Random phases with fresh settings; one long receiver hold in the first.
    for (int ph = 0; ph < 8; ph++) begin
      random_settings();
      if (ph == 0) hold_sink = 1'b1;
      if (ph == 6) calm = 1'b1;
      for (int k = 0; k < 166; k++) begin
        send_item(rand_item());
        if (k == 80) begin
          samples.valid <= 1'b0;
          while (pending_count != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_ins_velocity_position_blender passed");
    end else begin
      $display("tb_ins_velocity_position_blender failed");
    end
    $finish;
  end
endmodule

// ----- ins_velocity_position_blender.f -----
rtl/ivpb_pkg.sv
rtl/ivpb_in_if.sv
rtl/ivpb_out_if.sv
rtl/ins_velocity_position_blender.sv
test/ivpb_checker.sv
test/tb_ins_velocity_position_blender.sv
